>>> src/decimal_digit_glyph_renderer_top_defines.svh
// assertion macros for the decimal digit glyph renderer
// used at the end of the top level; expects clk and rst_n in scope
`ifndef DECIMAL_DIGIT_GLYPH_RENDERER_TOP_DEFINES_SVH
`define DECIMAL_DIGIT_GLYPH_RENDERER_TOP_DEFINES_SVH
`ifndef SYNTH
`define DDGR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddgr check failed");
`define DDGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddgr check failed");
`else
`define DDGR_ASSERT_SAME(lbl, ante, cons)
`define DDGR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/ddgr_pkg.sv
// shared types, constants and font table of the decimal digit glyph renderer
// no dependencies
package ddgr_pkg;

    localparam int VAL_W     = 27;
    localparam int PIX_W     = 56;
    localparam int GLYPH_W   = 7;
    localparam int ROWS      = 5;
    localparam int ROW_W     = 3;
    localparam int CNT_W     = 4;
    localparam int ITER_W    = 5;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd4;

    typedef logic [GLYPH_W-1:0] glyph_t;

    // status of the shift and add-3 unit
    typedef struct packed {
        logic busy;
        logic done;
    } dab_stat_t;

    // top row first, leftmost pixel in the high bit
    localparam glyph_t GLYPH_ROM [0:9][0:ROWS-1] = '{
        '{7'h1C, 7'h22, 7'h22, 7'h22, 7'h1C},
        '{7'h06, 7'h36, 7'h06, 7'h06, 7'h06},
        '{7'h1C, 7'h22, 7'h04, 7'h18, 7'h3E},
        '{7'h3C, 7'h02, 7'h1C, 7'h02, 7'h3C},
        '{7'h22, 7'h22, 7'h3E, 7'h02, 7'h02},
        '{7'h3E, 7'h20, 7'h3C, 7'h02, 7'h3C},
        '{7'h1C, 7'h20, 7'h3C, 7'h22, 7'h1C},
        '{7'h3E, 7'h04, 7'h08, 7'h10, 7'h20},
        '{7'h1C, 7'h22, 7'h1C, 7'h22, 7'h1C},
        '{7'h1C, 7'h22, 7'h1E, 7'h02, 7'h1C}
    };

    function automatic glyph_t glyph_row(input logic [3:0] d, input logic [ROW_W-1:0] r);
        glyph_t g;
        g = '0;
        if (d <= 4'd9 && r <= ROW_LAST)
        begin
            g = GLYPH_ROM[d][r];
        end
        return g;
    endfunction

    // largest value shown with n digits
    function automatic int digit_ceiling(input int n);
        int c;
        c = 1;
        for (int i = 0; i < n; i++)
        begin
            c = c * 10;
        end
        return c - 1;
    endfunction

endpackage

>>> src/ddgr_dabble.sv
// iterative binary to bcd converter: one shift and add-3 step per cycle
// depends on ddgr_pkg
module ddgr_dabble #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ddgr_pkg::VAL_W-1:0] value,
    output logic [4*MAX_DIGITS-1:0]   bcd,
    output ddgr_pkg::dab_stat_t       stat
);
    import ddgr_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [VAL_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
            bin_next  = {bin_reg[VAL_W-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(VAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd       = bcd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> src/ddgr_glyph.sv
// packs one font row of the left-aligned digits into the pixel word
// depends on ddgr_pkg for the font table
module ddgr_glyph #(
    parameter int MAX_DIGITS = 8
) (
    input  logic [4*MAX_DIGITS-1:0]      digits,
    input  logic [ddgr_pkg::CNT_W-1:0]   count,
    input  logic [ddgr_pkg::ROW_W-1:0]   row,
    output logic [ddgr_pkg::PIX_W-1:0]   pix
);
    import ddgr_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;

    always_comb
    begin
        pix = '0;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (k < int'(count))
            begin
                pix[PIX_W-1-GLYPH_W*k -: GLYPH_W] = glyph_row(digits[BCD_W-1-4*k -: 4], row);
            end
        end
    end

endmodule

>>> src/decimal_digit_glyph_renderer_top.sv
// decimal digit glyph renderer: converts one value to decimal and emits five font rows
// a request goes from idle through the shift/add-3 loop, the digit count and align states
// to the row state; a new request is taken only after the last row is issued (value_stall
// is high outside idle), and rows are held while the output is stalled
// a value over the digit limit gives a single too_large result through the over state,
// held while the output is stalled; reset clears the sequencer and output valid
// depends on ddgr_pkg, ddgr_dabble, ddgr_glyph and the assertion macro header
module decimal_digit_glyph_renderer_top #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic [ddgr_pkg::VAL_W-1:0]    value,
    output logic                          row_valid,
    input  logic                          row_stall,
    output logic [ddgr_pkg::PIX_W-1:0]    row_pixels,
    output logic [ddgr_pkg::ROW_W-1:0]    row_index,
    output logic [ddgr_pkg::CNT_W-1:0]    digit_count,
    output logic                          too_large,
    output logic                          last
);
    import ddgr_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int SH_W  = $clog2(BCD_W + 1);
    localparam logic [VAL_W-1:0] CEILING = VAL_W'(digit_ceiling(MAX_DIGITS));

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_COUNT = 6'b000100,
        S_ALIGN = 6'b001000,
        S_ROWS  = 6'b010000,
        S_OVER  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   shown_reg, shown_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BCD_W-1:0]   digit_reg, digit_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic [ROW_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               big_reg, big_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               over;
    logic               slot_free;
    logic               dab_start;
    logic [BCD_W-1:0]   bcd;
    dab_stat_t          dab_stat;
    logic [CNT_W-1:0]   lead_cnt;
    logic [SH_W-1:0]    sh_amt;
    logic [PIX_W-1:0]   row_pix;

    assign accept    = value_valid && !value_stall;
    assign over      = value > CEILING;
    assign slot_free = !out_valid_reg || !row_stall;
    assign dab_start = accept && !over;

    ddgr_dabble #(.MAX_DIGITS(MAX_DIGITS)) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .value (value),
        .bcd   (bcd),
        .stat  (dab_stat)
    );

    ddgr_glyph #(.MAX_DIGITS(MAX_DIGITS)) u_glyph (
        .digits (digit_reg),
        .count  (shown_reg),
        .row    (row_reg),
        .pix    (row_pix)
    );

    // digits up to the most significant nonzero one
    always_comb
    begin
        lead_cnt = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] != 4'd0)
            begin
                lead_cnt = CNT_W'(i + 1);
            end
        end
    end

    // move the leading digit to the top nibble
    assign sh_amt = SH_W'(4 * (MAX_DIGITS - int'(shown_reg)));

    always_comb
    begin
        state_next     = state_reg;
        shown_next     = shown_reg;
        row_next       = row_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        big_next       = big_reg;
        last_next      = last_reg;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (over)
                    begin
                        shown_next = '0;
                        state_next = S_OVER;
                    end
                    else
                    begin
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV:
            begin
                if (dab_stat.done)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                shown_next = lead_cnt;
                state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                digit_next = bcd << sh_amt;
                row_next   = '0;
                state_next = S_ROWS;
            end
            S_ROWS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    pix_next       = row_pix;
                    idx_next       = row_reg;
                    cnt_next       = shown_reg;
                    big_next       = 1'b0;
                    last_next      = (row_reg == ROW_LAST);
                    if (row_reg == ROW_LAST)
                    begin
                        row_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            S_OVER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    pix_next       = '0;
                    idx_next       = '0;
                    cnt_next       = '0;
                    big_next       = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shown_reg     <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shown_reg     <= shown_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        pix_reg   <= pix_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        big_reg   <= big_next;
        last_reg  <= last_next;
    end

    assign value_stall = (state_reg != S_IDLE);
    assign row_valid   = out_valid_reg;
    assign row_pixels  = pix_reg;
    assign row_index   = idx_reg;
    assign digit_count = cnt_reg;
    assign too_large   = big_reg;
    assign last        = last_reg;

`include "decimal_digit_glyph_renderer_top_defines.svh"

    `DDGR_ASSERT_NEXT(a_over_goes_out, accept && over, state_reg == S_OVER)
    `DDGR_ASSERT_SAME(a_big_alone, row_valid && too_large, last && digit_count == '0 && row_pixels == '0)
    `DDGR_ASSERT_SAME(a_last_row, row_valid && last && !too_large, row_index == ROW_LAST)
    `DDGR_ASSERT_SAME(a_count_range, row_valid, int'(digit_count) <= MAX_DIGITS)

endmodule

>>> dv/decimal_digit_glyph_renderer_top_test.sv
// self-checking testbench for decimal_digit_glyph_renderer_top: random requests with idling
// on both sides, every font row checked against a built-in digit split and glyph predictor
// depends on ddgr_pkg and the renderer RTL
module decimal_digit_glyph_renderer_top_test;

    import ddgr_pkg::*;

    localparam int DIGIT_CEILING = 99999999;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 60;

    // 5x7 font, top row first, leftmost pixel in the high bit
    localparam logic [0:9][0:4][6:0] FONT = {
        7'h1C, 7'h22, 7'h22, 7'h22, 7'h1C,
        7'h06, 7'h36, 7'h06, 7'h06, 7'h06,
        7'h1C, 7'h22, 7'h04, 7'h18, 7'h3E,
        7'h3C, 7'h02, 7'h1C, 7'h02, 7'h3C,
        7'h22, 7'h22, 7'h3E, 7'h02, 7'h02,
        7'h3E, 7'h20, 7'h3C, 7'h02, 7'h3C,
        7'h1C, 7'h20, 7'h3C, 7'h22, 7'h1C,
        7'h3E, 7'h04, 7'h08, 7'h10, 7'h20,
        7'h1C, 7'h22, 7'h1C, 7'h22, 7'h1C,
        7'h1C, 7'h22, 7'h1E, 7'h02, 7'h1C
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixels;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] count;
        logic             over;
        logic             final_row;
    } glyph_row_t;

    typedef struct {
        logic [VAL_W-1:0] val;
        bit               drain;
    } value_req_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             value_valid = 1'b0;
    logic             value_stall;
    logic [VAL_W-1:0] value = '0;
    logic             row_valid;
    logic             row_stall = 1'b0;
    logic [PIX_W-1:0] row_pixels;
    logic [ROW_W-1:0] row_index;
    logic [CNT_W-1:0] digit_count;
    logic             too_large;
    logic             last;

    value_req_t pending_values[$];
    glyph_row_t expected_rows[$];
    int         mismatch_count = 0;
    int         send_gap = 0;
    int         send_calm = 0;
    int         recv_wait = 0;
    int         recv_calm = 0;
    int         idle_cycles = 0;

    decimal_digit_glyph_renderer_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .row_valid   (row_valid),
        .row_stall   (row_stall),
        .row_pixels  (row_pixels),
        .row_index   (row_index),
        .digit_count (digit_count),
        .too_large   (too_large),
        .last        (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // flag a value over the ceiling, else split into decimal digits, drop leading zeros, stack the glyph rows
    function automatic void predict_glyph_rows(input logic [VAL_W-1:0] v);
        glyph_row_t       r;
        logic [3:0]       digits [8];
        logic [PIX_W-1:0] glyph;
        int               n;
        int               t;
        r = '0;
        if (int'(v) > DIGIT_CEILING)
        begin
            r.over = 1'b1;
            r.final_row = 1'b1;
            expected_rows.push_back(r);
            return;
        end
        n = 0;
        t = int'(v);
        while (t > 0)
        begin
            n++;
            t = t / 10;
        end
        t = int'(v);
        for (int k = n - 1; k >= 0; k--)
        begin
            digits[k] = 4'(t % 10);
            t = t / 10;
        end
        for (int row = 0; row < ROWS; row++)
        begin
            r.pixels = '0;
            for (int k = 0; k < n; k++)
            begin
                glyph = '0;
                glyph[GLYPH_W-1:0] = FONT[digits[k]][row];
                r.pixels = r.pixels | (glyph << (49 - GLYPH_W * k));
            end
            r.row = ROW_W'(row);
            r.count = CNT_W'(n);
            r.over = 1'b0;
            r.final_row = (ROW_W'(row) == ROW_LAST);
            expected_rows.push_back(r);
        end
    endfunction

    // per request wait, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        int n;
        int lo;
        case ($urandom_range(0, 19))
            0:       return VAL_W'($urandom_range(0, 9));
            1, 2, 3: return VAL_W'($urandom_range(DIGIT_CEILING + 1, 134217727));
            4:       return VAL_W'($urandom);
            default:
            begin
                n = $urandom_range(1, 8);
                lo = 1;
                for (int i = 1; i < n; i++)
                begin
                    lo = lo * 10;
                end
                return VAL_W'($urandom_range(lo, lo * 10 - 1));
            end
        endcase
    endfunction

    function automatic void queue_value(input int v, input bit drain);
        value_req_t req;
        req.val = VAL_W'(v);
        req.drain = drain;
        pending_values.push_back(req);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_valid <= 1'b0;
            value <= '0;
        end
        else
        begin
            if (value_valid && !value_stall)
            begin
                predict_glyph_rows(value);
                void'(pending_values.pop_front());
                send_gap = draw_wait(send_calm);
            end
            if (value_valid && value_stall)
            begin
                // hold the stalled request
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                value_valid <= 1'b0;
            end
            else if (pending_values.size() > 0 &&
                     !(pending_values[0].drain && expected_rows.size() != 0))
            begin
                value_valid <= 1'b1;
                value <= pending_values[0].val;
            end
            else
            begin
                value_valid <= 1'b0;
            end
        end
    end

    // row monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_stall <= 1'b0;
        end
        else if (row_valid && !row_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row: row_index %0d last %b", row_index, last);
                mismatch_count++;
            end
            else
            begin
                if (expected_rows[0].pixels !== row_pixels)
                begin
                    $error("row_pixels: expected %h, actual %h",
                           expected_rows[0].pixels, row_pixels);
                    mismatch_count++;
                end
                if (expected_rows[0].row !== row_index)
                begin
                    $error("row_index: expected %0d, actual %0d",
                           expected_rows[0].row, row_index);
                    mismatch_count++;
                end
                if (expected_rows[0].count !== digit_count)
                begin
                    $error("digit_count: expected %0d, actual %0d",
                           expected_rows[0].count, digit_count);
                    mismatch_count++;
                end
                if (expected_rows[0].over !== too_large)
                begin
                    $error("too_large: expected %b, actual %b",
                           expected_rows[0].over, too_large);
                    mismatch_count++;
                end
                if (expected_rows[0].final_row !== last)
                begin
                    $error("last: expected %b, actual %b",
                           expected_rows[0].final_row, last);
                    mismatch_count++;
                end
                void'(expected_rows.pop_front());
            end
            recv_wait = draw_wait(recv_calm);
            row_stall <= (recv_wait != 0);
        end
        else if (recv_wait > 0)
        begin
            recv_wait--;
            row_stall <= (recv_wait != 0);
        end
        else
        begin
            row_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((value_valid && !value_stall) || (row_valid && !row_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        // zero, values of every digit count, every digit, limit edge, all ones
        queue_value(0, 1'b0);
        queue_value(1, 1'b0);
        queue_value(9, 1'b0);
        queue_value(10, 1'b0);
        queue_value(42, 1'b0);
        queue_value(305, 1'b0);
        queue_value(6789, 1'b0);
        queue_value(10000, 1'b0);
        queue_value(500000, 1'b0);
        queue_value(9000001, 1'b0);
        queue_value(12345678, 1'b0);
        queue_value(90909090, 1'b0);
        queue_value(88888888, 1'b0);
        queue_value(DIGIT_CEILING, 1'b0);
        queue_value(DIGIT_CEILING + 1, 1'b0);
        queue_value(134217727, 1'b0);
        queue_value(67108864, 1'b0);
        queue_value(0, 1'b0);
        queue_value(7, 1'b0);
        for (int i = 0; i < 200; i++)
        begin
            // let the block drain fully before a few requests
            queue_value(int'(random_value()), (i == 0) || (i == 100) || (i == 150));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || expected_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
